### sv/afc_pkg.sv
// Package: types and constants shared by the Adler-32 frame checker files.
`default_nettype none

package afc_pkg;

  // Adler-32 modulus, sized for the 17-bit intermediate sums.
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [15:0] IdxMax   = 16'hffff;

  // Longest buffer that still fails the length check.
  localparam logic [16:0] MinFrameLen = 17'd8;
  // Fixed overhead: length, name length, checksum.
  localparam logic [15:0] HdrTrlLen   = 16'd8;
  // Offset of the first name byte.
  localparam logic [16:0] NameOffset  = 17'd4;
  // Length of the trailing check field.
  localparam logic [16:0] CheckLen    = 17'd4;

  typedef enum logic [2:0] {
    ClassLength   = 3'd0,
    ClassNameLen  = 3'd1,
    ClassName     = 3'd2,
    ClassPayload  = 3'd3,
    ClassChecksum = 3'd4
  } byte_class_e;

  typedef enum logic [2:0] {
    StatusOk           = 3'd0,
    StatusTooShort     = 3'd1,
    StatusLenMismatch  = 3'd2,
    StatusNameShort    = 3'd3,
    StatusPayloadShort = 3'd4,
    StatusChecksumBad  = 3'd5
  } status_e;

endpackage

`default_nettype wire

### sv/afc_if.sv
// Interfaces: input byte stream and result stream of the frame checker.
`default_nettype none

interface afc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface afc_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_out;
  afc_pkg::byte_class_e byte_class;
  logic                 frame_done;
  afc_pkg::status_e     status;
  logic [15:0]          payload_length;

  modport source (output valid, output data_out, output byte_class, output frame_done,
                  output status, output payload_length, input ready);
  modport sink   (input valid, input data_out, input byte_class, input frame_done,
                  input status, input payload_length, output ready);
endinterface

`default_nettype wire

### sv/adler32_frame_checker_core.sv
// Top level: Adler-32 frame checker, one byte per cycle unless out_o stalls.
//
// Usage:
//   in_i  (sink)   : one byte of the received frame per transaction; last_byte
//                    marks the final byte of the buffer.
//   out_o (source) : one result transaction per input byte: the byte passed
//                    through, its class tag, and on the last byte frame_done,
//                    the status and (status ok only) the payload length.
//   Frame layout   : 16-bit LE total length, 16-bit LE name length, name,
//                    payload, 32-bit LE Adler-32 over bytes 2 .. length-5.
// Result: registered, on out_o in the cycle after the byte's transaction.
// Throughput: one byte per cycle unless out_o stalls. The frame state (index,
//   lengths, running Adler sums, last four bytes) updates in the same cycle
//   the byte is taken; the longest path is the two add/conditional-subtract
//   steps of the sums followed by the 32-bit checksum compare.
// Stall: a single output register parts the two sides; in_i.ready is high
//   while that register is empty or being drained this cycle, so a stalled
//   receiver holds at most one finished result and back-pressures the input.
// Reset: rst_ni clears the output valid and returns the frame state to its
//   start values (sums 1/0); the block can take a byte right after reset.
//   The frame state also returns to start values after every last byte.
`default_nettype none

module adler32_frame_checker_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  afc_in_if.sink      in_i,
  afc_out_if.source   out_o
);

  // Frame state
  logic [15:0] byte_index_q, byte_index_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] name_length_q, name_length_d;
  logic [15:0] sum_low_q, sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;
  logic [31:0] rx_check_q, rx_check_d;

  // Result register
  logic                 out_valid_q;
  logic [7:0]           data_out_q;
  afc_pkg::byte_class_e byte_class_q, byte_class_d;
  logic                 frame_done_q;
  afc_pkg::status_e     status_q, status_d;
  logic [15:0]          plen_q, plen_d;

  logic        in_fire;
  logic [7:0]  b;
  logic        last;
  logic [16:0] idx_w;
  logic [16:0] len_w;
  logic        sum_en;
  logic [16:0] low_add, high_add;
  logic [15:0] low_new, high_new;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.byte_in;
  assign last       = in_i.last_byte;
  assign idx_w      = {1'b0, byte_index_q};
  assign len_w      = idx_w + 17'd1;

  // Class tag, from the state before this byte
  always_comb begin
    priority if (byte_index_q < 16'd2) begin
      byte_class_d = afc_pkg::ClassLength;
    end else if (byte_index_q < 16'd4) begin
      byte_class_d = afc_pkg::ClassNameLen;
    end else if (idx_w < ({1'b0, name_length_q} + afc_pkg::NameOffset)) begin
      byte_class_d = afc_pkg::ClassName;
    end else if ((idx_w + afc_pkg::CheckLen) >= {1'b0, frame_length_q}) begin
      byte_class_d = afc_pkg::ClassChecksum;
    end else begin
      byte_class_d = afc_pkg::ClassPayload;
    end
  end

  // Header fields
  always_comb begin
    frame_length_d = frame_length_q;
    name_length_d  = name_length_q;
    unique case (byte_index_q)
      16'd0:   frame_length_d = {8'h00, b};
      16'd1:   frame_length_d = {b, frame_length_q[7:0]};
      16'd2:   name_length_d  = {8'h00, b};
      16'd3:   name_length_d  = {b, name_length_q[7:0]};
      default: ;
    endcase
  end

  // Running Adler sums; the length is settled once the index passes 1
  assign sum_en = (byte_index_q >= 16'd2) &&
                  ((idx_w + afc_pkg::CheckLen) < {1'b0, frame_length_q});

  always_comb begin
    low_add = {1'b0, sum_low_q} + {9'd0, b};
    if (low_add >= afc_pkg::AdlerMod) begin
      low_add = low_add - afc_pkg::AdlerMod;
    end
    low_new  = low_add[15:0];
    high_add = {1'b0, sum_high_q} + {1'b0, low_new};
    if (high_add >= afc_pkg::AdlerMod) begin
      high_add = high_add - afc_pkg::AdlerMod;
    end
    high_new = high_add[15:0];
  end

  assign sum_low_d  = sum_en ? low_new  : sum_low_q;
  assign sum_high_d = sum_en ? high_new : sum_high_q;
  assign rx_check_d = {b, rx_check_q[31:8]};

  // End-of-frame checks, first match wins
  always_comb begin
    status_d = afc_pkg::StatusOk;
    plen_d   = 16'd0;
    if (last) begin
      priority if (len_w <= afc_pkg::MinFrameLen) begin
        status_d = afc_pkg::StatusTooShort;
      end else if (len_w != {1'b0, frame_length_d}) begin
        status_d = afc_pkg::StatusLenMismatch;
      end else if (name_length_d <= 16'd1) begin
        status_d = afc_pkg::StatusNameShort;
      end else if (({1'b0, name_length_d} + 17'd10) > len_w) begin
        // also catches a name longer than the frame
        status_d = afc_pkg::StatusPayloadShort;
      end else if ({sum_high_d, sum_low_d} != rx_check_d) begin
        status_d = afc_pkg::StatusChecksumBad;
      end else begin
        plen_d = len_w[15:0] - name_length_d - afc_pkg::HdrTrlLen;
      end
    end
  end

  assign byte_index_d = (byte_index_q < afc_pkg::IdxMax) ? (byte_index_q + 16'd1)
                                                        : byte_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      frame_length_q <= '0;
      name_length_q  <= '0;
      sum_low_q      <= 16'd1;
      sum_high_q     <= '0;
      rx_check_q     <= '0;
    end else if (in_fire) begin
      if (last) begin
        byte_index_q   <= '0;
        frame_length_q <= '0;
        name_length_q  <= '0;
        sum_low_q      <= 16'd1;
        sum_high_q     <= '0;
        rx_check_q     <= '0;
      end else begin
        byte_index_q   <= byte_index_d;
        frame_length_q <= frame_length_d;
        name_length_q  <= name_length_d;
        sum_low_q      <= sum_low_d;
        sum_high_q     <= sum_high_d;
        rx_check_q     <= rx_check_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_out_q   <= b;
      byte_class_q <= byte_class_d;
      frame_done_q <= last;
      status_q     <= status_d;
      plen_q       <= plen_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data_out       = data_out_q;
  assign out_o.byte_class     = byte_class_q;
  assign out_o.frame_done     = frame_done_q;
  assign out_o.status         = status_q;
  assign out_o.payload_length = plen_q;

  // Running sums stay reduced modulo 65521
  a_low_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_low_q} < afc_pkg::AdlerMod)
    else $error("sum_low out of range");

  a_high_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_high_q} < afc_pkg::AdlerMod)
    else $error("sum_high out of range");

  // Status and length only on the end-of-frame result
  a_mid_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_done_q |-> status_q == afc_pkg::StatusOk && plen_q == 16'd0)
    else $error("status or length on a mid-frame result");

  a_len_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != afc_pkg::StatusOk |-> plen_q == 16'd0)
    else $error("payload length on a failed frame");

  // A last byte restarts the frame state
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last |=> byte_index_q == 16'd0 && sum_low_q == 16'd1 && sum_high_q == 16'd0)
    else $error("frame state not restarted after last byte");

endmodule

`default_nettype wire
